>>> sv/luma_edge_deblock_filter_core_defines.svh
// Assertion macros shared by the luma deblocking filter RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef LUMA_EDGE_DEBLOCK_FILTER_CORE_DEFINES_SVH
`define LUMA_EDGE_DEBLOCK_FILTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define LEDF_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ledf assertion violated");

// Consequent must hold in the same cycle as the antecedent.
`define LEDF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ledf assertion violated");

// Consequent must hold in the cycle after the antecedent.
`define LEDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ledf assertion violated");

`else

`define LEDF_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define LEDF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define LEDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/ledf_pkg.sv
// Types shared by the luma deblocking filter: line, result, edge classification and queue entry.
// No dependencies.
`default_nettype none

package ledf_pkg;

    typedef struct packed {
        logic [7:0] p3;
        logic [7:0] p2;
        logic [7:0] p1;
        logic [7:0] p0;
        logic [7:0] q0;
        logic [7:0] q1;
        logic [7:0] q2;
        logic [7:0] q3;
        logic       strong_mode;
        logic [4:0] tc0_limit;
        logic [7:0] alpha_thresh;
        logic [4:0] beta_thresh;
    } line_t;

    typedef struct packed {
        logic [7:0] out_p2;
        logic [7:0] out_p1;
        logic [7:0] out_p0;
        logic [7:0] out_q0;
        logic [7:0] out_q1;
        logic [7:0] out_q2;
        logic       was_filtered;
    } result_t;

    // Edge classification made by the front end.
    typedef struct packed {
        logic gate;
        logic ap;
        logic aq;
        logic small_step;
    } cls_t;

    typedef struct packed {
        line_t line;
        cls_t  cls;
    } entry_t;

endpackage

`default_nettype wire

>>> sv/luma_edge_deblock_filter_core.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------
// line in   | push / full        | line   (ledf_pkg::line_t)
// result    | empty / pop        | result (ledf_pkg::result_t)
//
// Sustains one edge line per clock while full is low and results are popped; a pushed
// line is registered into the classification queue, then into the output register.
// The filter datapath computes a line combinationally from the queue head.
// full rises only when the queue holds QUEUE_DEPTH lines while the output stalls.
// Reset empties the queue and the output register; no clearing pass is needed.
// Top level of the luma deblocking filter; depends on ledf_pkg, ledf_front,
// ledf_queue and ledf_back.
`default_nettype none

module luma_edge_deblock_filter_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire ledf_pkg::line_t line,
    output logic                 empty,
    input  wire logic            pop,
    output ledf_pkg::result_t    result
);

    ledf_pkg::entry_t wr_entry;
    ledf_pkg::entry_t head;
    logic             wr;
    logic             rd;
    logic             q_empty;
    logic             q_full;

    ledf_front u_front (
        .push   (push),
        .line   (line),
        .q_full (q_full),
        .wr     (wr),
        .entry  (wr_entry)
    );

    ledf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wdata   (wr_entry),
        .rd      (rd),
        .rdata   (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    ledf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .rd      (rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    assign full = q_full;

endmodule

`default_nettype wire

>>> sv/ledf_front.sv
// Front end of the deblocking filter: accepts a line and classifies the edge.
// Depends on ledf_pkg.
`default_nettype none

module ledf_front (
    input  wire logic           push,
    input  wire ledf_pkg::line_t line,
    input  wire logic           q_full,
    output logic                wr,
    output ledf_pkg::entry_t    entry
);

    logic [7:0] d_p0q0;
    logic [7:0] d_p1p0;
    logic [7:0] d_q1q0;
    logic [7:0] d_p2p0;
    logic [7:0] d_q2q0;
    logic [7:0] beta_ext;
    logic [8:0] small_lim;

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign d_p0q0 = absdiff(line.p0, line.q0);
    assign d_p1p0 = absdiff(line.p1, line.p0);
    assign d_q1q0 = absdiff(line.q1, line.q0);
    assign d_p2p0 = absdiff(line.p2, line.p0);
    assign d_q2q0 = absdiff(line.q2, line.q0);
    assign beta_ext = {3'b000, line.beta_thresh};
    assign small_lim = {3'b000, line.alpha_thresh[7:2]} + 9'd2;

    always_comb
    begin
        entry.line           = line;
        entry.cls.gate       = (d_p0q0 < line.alpha_thresh) && (d_p1p0 < beta_ext)
                               && (d_q1q0 < beta_ext);
        entry.cls.ap         = d_p2p0 < beta_ext;
        entry.cls.aq         = d_q2q0 < beta_ext;
        entry.cls.small_step = {1'b0, d_p0q0} < small_lim;
    end

    assign wr = push && !q_full;

endmodule

`default_nettype wire

>>> sv/ledf_queue.sv
// Short queue of classified lines between the front end and the filter.
// Depends on ledf_pkg and the assertion macros header.
`default_nettype none
`include "luma_edge_deblock_filter_core_defines.svh"

module ledf_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire ledf_pkg::entry_t wdata,
    input  wire logic             rd,
    output ledf_pkg::entry_t      rdata,
    output logic                  q_empty,
    output logic                  q_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ledf_pkg::entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr, rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata   = entries_reg[rd_ptr_reg];
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));

    `LEDF_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `LEDF_ASSERT_IMPLIES(a_no_read_empty, clk, rst_n, rd, count_reg != '0)
    `LEDF_ASSERT_IMPLIES(a_no_write_full, clk, rst_n, wr, count_reg != CNT_W'(DEPTH))
    `LEDF_ASSERT_NEXT(a_count_up, clk, rst_n, wr && !rd, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

>>> sv/ledf_back.sv
// Back end of the deblocking filter: applies the normal or strong filter to
// the queue head and holds the result in an output register.
// Depends on ledf_pkg and the assertion macros header.
`default_nettype none
`include "luma_edge_deblock_filter_core_defines.svh"

module ledf_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ledf_pkg::entry_t head,
    input  wire logic             q_empty,
    output logic                  rd,
    input  wire logic             pop,
    output logic                  empty,
    output ledf_pkg::result_t     result
);

    logic              valid_reg, valid_next;
    ledf_pkg::result_t result_reg, result_next;
    logic              load;

    logic [11:0]        sp0, sp1, sp2, sq0, sq1, sq2, wp0, wq0;
    logic [8:0]         avg_sum;
    logic signed [11:0] dsum, delta_raw, delta, tcs, tc0s;
    logic [6:0]         tc;
    logic signed [11:0] tp, tq, tp_clip, tq_clip;
    logic [7:0]         np0, nq0, np1, nq1;

    function automatic logic [11:0] z12(input logic [7:0] v);
        z12 = {4'b0000, v};
    endfunction

    function automatic logic signed [11:0] s12(input logic [7:0] v);
        s12 = $signed({4'b0000, v});
    endfunction

    function automatic logic signed [11:0] clip3(input logic signed [11:0] lo,
                                                  input logic signed [11:0] hi,
                                                  input logic signed [11:0] v);
        if (v < lo)
        begin
            clip3 = lo;
        end
        else if (v > hi)
        begin
            clip3 = hi;
        end
        else
        begin
            clip3 = v;
        end
    endfunction

    function automatic logic [7:0] clip255(input logic signed [11:0] v);
        if (v < 12'sd0)
        begin
            clip255 = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            clip255 = 8'd255;
        end
        else
        begin
            clip255 = v[7:0];
        end
    endfunction

    // Strong filter sums; all fit in 11 bits before the shift.
    always_comb
    begin
        sp0 = z12(head.line.p2) + (z12(head.line.p1) << 1)
              + (z12(head.line.p0) << 1) + (z12(head.line.q0) << 1)
              + z12(head.line.q1) + 12'd4;
        sp1 = z12(head.line.p2) + z12(head.line.p1) + z12(head.line.p0)
              + z12(head.line.q0) + 12'd2;
        sp2 = (z12(head.line.p3) << 1) + (z12(head.line.p2) << 1) + z12(head.line.p2)
              + z12(head.line.p1) + z12(head.line.p0) + z12(head.line.q0) + 12'd4;
        sq0 = z12(head.line.p1) + (z12(head.line.p0) << 1)
              + (z12(head.line.q0) << 1) + (z12(head.line.q1) << 1)
              + z12(head.line.q2) + 12'd4;
        sq1 = z12(head.line.p0) + z12(head.line.q0) + z12(head.line.q1)
              + z12(head.line.q2) + 12'd2;
        sq2 = (z12(head.line.q3) << 1) + (z12(head.line.q2) << 1) + z12(head.line.q2)
              + z12(head.line.q1) + z12(head.line.q0) + z12(head.line.p0) + 12'd4;
        wp0 = (z12(head.line.p1) << 1) + z12(head.line.p0) + z12(head.line.q1) + 12'd2;
        wq0 = (z12(head.line.q1) << 1) + z12(head.line.q0) + z12(head.line.p1) + 12'd2;
    end

    // Normal filter: clipped delta on p0/q0, bounded tap on p1/q1.
    always_comb
    begin
        dsum      = ((s12(head.line.q0) - s12(head.line.p0)) <<< 2)
                    + (s12(head.line.p1) - s12(head.line.q1)) + 12'sd4;
        delta_raw = dsum >>> 3;
        tc        = {2'b00, head.line.tc0_limit} + {6'd0, head.cls.ap}
                    + {6'd0, head.cls.aq};
        tcs       = $signed({5'b00000, tc});
        tc0s      = $signed({7'b0000000, head.line.tc0_limit});
        delta     = clip3(-tcs, tcs, delta_raw);
        np0       = clip255(s12(head.line.p0) + delta);
        nq0       = clip255(s12(head.line.q0) - delta);
        avg_sum   = {1'b0, head.line.p0} + {1'b0, head.line.q0} + 9'd1;
        tp        = (s12(head.line.p2) + s12(avg_sum[8:1])
                    - (s12(head.line.p1) <<< 1)) >>> 1;
        tq        = (s12(head.line.q2) + s12(avg_sum[8:1])
                    - (s12(head.line.q1) <<< 1)) >>> 1;
        tp_clip   = clip3(-tc0s, tc0s, tp);
        tq_clip   = clip3(-tc0s, tc0s, tq);
        np1       = clip255(s12(head.line.p1) + tp_clip);
        nq1       = clip255(s12(head.line.q1) + tq_clip);
    end

    assign load = !q_empty && (!valid_reg || pop);
    assign rd   = load;

    always_comb
    begin
        valid_next              = valid_reg;
        result_next             = result_reg;
        if (pop && valid_reg)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next               = 1'b1;
            result_next.out_p2       = head.line.p2;
            result_next.out_p1       = head.line.p1;
            result_next.out_p0       = head.line.p0;
            result_next.out_q0       = head.line.q0;
            result_next.out_q1       = head.line.q1;
            result_next.out_q2       = head.line.q2;
            result_next.was_filtered = head.cls.gate;
            if (head.cls.gate && head.line.strong_mode)
            begin
                if (head.cls.ap && head.cls.small_step)
                begin
                    result_next.out_p0 = sp0[10:3];
                    result_next.out_p1 = sp1[9:2];
                    result_next.out_p2 = sp2[10:3];
                end
                else
                begin
                    result_next.out_p0 = wp0[9:2];
                end
                if (head.cls.aq && head.cls.small_step)
                begin
                    result_next.out_q0 = sq0[10:3];
                    result_next.out_q1 = sq1[9:2];
                    result_next.out_q2 = sq2[10:3];
                end
                else
                begin
                    result_next.out_q0 = wq0[9:2];
                end
            end
            else if (head.cls.gate)
            begin
                result_next.out_p0 = np0;
                result_next.out_q0 = nq0;
                if (head.cls.ap)
                begin
                    result_next.out_p1 = np1;
                end
                if (head.cls.aq)
                begin
                    result_next.out_q1 = nq1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign empty  = !valid_reg;
    assign result = result_reg;

    // A line that fails the gate leaves the filter untouched.
    `LEDF_ASSERT_NEXT(a_pass_thru, clk, rst_n, load && !head.cls.gate, !result_reg.was_filtered && result_reg.out_p0 == $past(head.line.p0) && result_reg.out_q0 == $past(head.line.q0) && result_reg.out_p1 == $past(head.line.p1) && result_reg.out_q1 == $past(head.line.q1))
    // Hold a waiting result until it is taken.
    `LEDF_ASSERT_NEXT(a_hold_result, clk, rst_n, valid_reg && !pop, valid_reg && $stable(result_reg))

endmodule

`default_nettype wire
